// ===== design/ibm2ieee_pkg.sv =====
// Package for the IBM hexadecimal float to IEEE-754 single converter.
// Holds the field widths, the mode and status codes, and the conversion functions.
// It has no dependencies of its own.
`default_nettype none

package ibm2ieee_pkg;

    // Payload widths.
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // Mode register codes. Codes above MODE_PASS behave as pass.
    localparam logic [MODE_W-1:0] MODE_CONVERT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REV_CONVERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SWAP_HALVES = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REV_ONLY    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PASS        = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // IEEE-754 single fields.
    localparam logic [WORD_W-1:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] IEEE_INF  = 32'h7f80_0000;

    // Converted word together with its status.
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] status;
    } t_conv;

    // Reverse all four bytes of a word.
    function automatic logic [WORD_W-1:0] byte_reverse(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Swap the two bytes within each 16-bit half.
    function automatic logic [WORD_W-1:0] swap_in_halves(input logic [WORD_W-1:0] w);
        return {w[23:16], w[31:24], w[7:0], w[15:8]};
    endfunction

    // Count leading zeros of a nonzero 24-bit fraction (0 to 23).
    function automatic logic [4:0] clz24(input logic [23:0] f);
        logic [4:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (f[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

    // IBM hexadecimal single to IEEE-754 single, truncating.
    function automatic t_conv ibm_to_ieee(input logic [WORD_W-1:0] w);
        logic              sign;
        logic [6:0]        hexp;
        logic [23:0]       frac;
        logic [4:0]        lz;
        logic [23:0]       norm;
        logic signed [9:0] e;
        t_conv             r;
        sign = w[31];
        hexp = w[30:24];
        frac = w[23:0];
        lz   = clz24(frac);
        norm = frac << lz;
        // Biased exponent: 4*(E-64) - 1 - lz + 127 = 4*E - 130 - lz.
        e    = signed'({1'b0, hexp, 2'b00}) - 10'sd130 - signed'({5'd0, lz});
        r.status = ST_OK;
        if (frac == '0 || hexp == '0) begin
            r.word = w & SIGN_MASK;
        end else if (e >= 10'sd255) begin
            r.status = ST_OVERFLOW;
            r.word   = (w & SIGN_MASK) | IEEE_INF;
        end else if (e <= 10'sd0) begin
            r.status = ST_UNDERFLOW;
            r.word   = w & SIGN_MASK;
        end else begin
            r.word = {sign, e[7:0], norm[22:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/ibm2ieee_in_if.sv =====
// Input channel interface: one word and its last-word mark per transaction.
// Depends on ibm2ieee_pkg for the word width.
`default_nettype none

interface ibm2ieee_in_if
    import ibm2ieee_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] in_word;
    logic              last_in;

    modport source (output valid, output in_word, output last_in, input ready);
    modport sink   (input valid, input in_word, input last_in, output ready);
endinterface

`default_nettype wire

// ===== design/ibm2ieee_out_if.sv =====
// Output channel interface: result word, status and last-word mark per transaction.
// Depends on ibm2ieee_pkg for the word and status widths.
`default_nettype none

interface ibm2ieee_out_if
    import ibm2ieee_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   out_word;
    logic [STATUS_W-1:0] status;
    logic                last_out;

    modport source (output valid, output out_word, output status, output last_out,
                    input ready);
    modport sink   (input valid, input out_word, input status, input last_out,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ibm2ieee_cfg_if.sv =====
// Configuration write channel interface: carries the mode register write data.
// Depends on ibm2ieee_pkg for the mode width.
`default_nettype none

interface ibm2ieee_cfg_if
    import ibm2ieee_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;

    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

`default_nettype wire

// ===== design/ibm_to_ieee_float_convert.sv =====
// Top level of the IBM hexadecimal float to IEEE-754 single converter.
// Depends on ibm2ieee_pkg and the three channel interfaces.
//
//   Channel   Direction  Transaction carries
//   i_in      sink       in_word (32), last_in (1)
//   o_out     source     out_word (32), status (2), last_out (1)
//   i_cfg     sink       mode (3), always ready
//
// Two register stages: an input register, then the byte swap, leading-zero count
// and exponent adjust in one pass of logic into the result register.
// An accepted word is held in the input register and then in the result register, whose
// valid bit opens the result transaction; one item is taken every cycle while the
// output side keeps taking results.
// A stall on the output holds both stages; the input stage still fills if empty.
// Reset clears the valid bits and sets the mode to convert.
`default_nettype none

module ibm_to_ieee_float_convert
    import ibm2ieee_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    ibm2ieee_in_if.sink    i_in,
    ibm2ieee_out_if.source o_out,
    ibm2ieee_cfg_if.sink   i_cfg
);

    logic [MODE_W-1:0]   r_mode;
    logic                r_s1_valid;
    logic [WORD_W-1:0]   r_s1_word;
    logic                r_s1_last;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_last;

    logic                out_free;
    logic                s1_free;
    t_conv               n_result;

    // Stage hand-off: the result register frees when empty or taken.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_free    = !r_s1_valid || out_free;
    assign i_in.ready = s1_free;
    assign i_cfg.ready = 1'b1;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CONVERT;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.mode;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_s1_word <= i_in.in_word;
            r_s1_last <= i_in.last_in;
        end
    end

    // Mode-dependent datapath between the two registers.
    always_comb begin
        n_result.status = ST_OK;
        case (r_mode)
            MODE_CONVERT:     n_result = ibm_to_ieee(r_s1_word);
            MODE_REV_CONVERT: n_result = ibm_to_ieee(byte_reverse(r_s1_word));
            MODE_SWAP_HALVES: n_result.word = swap_in_halves(r_s1_word);
            MODE_REV_ONLY:    n_result.word = byte_reverse(r_s1_word);
            default:          n_result.word = r_s1_word;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_word   <= n_result.word;
            r_out_status <= n_result.status;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_word = r_out_word;
    assign o_out.status   = r_out_status;
    assign o_out.last_out = r_out_last;

endmodule

`default_nettype wire

// ===== verif/ibm_to_ieee_float_convert_tb.sv =====
// Self-checking testbench for the IBM hexadecimal float to IEEE-754 single converter.
// Drives words through every mode, predicts each result and compares it field by field.
// Depends on ibm2ieee_pkg, the three channel interfaces and ibm_to_ieee_float_convert.

module ibm_to_ieee_float_convert_tb;
    import ibm2ieee_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode codes without a function of their own; the block passes words through.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 63;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 80;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } word_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] status;
        logic                last;
    } ieee_result_t;

    logic clk;
    logic rst_n;

    ibm2ieee_in_if  in_ch ();
    ibm2ieee_out_if out_ch ();
    ibm2ieee_cfg_if cfg_ch ();

    ibm_to_ieee_float_convert uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    word_item_t   pending_words[$];
    ieee_result_t predicted_results[$];

    logic [MODE_W-1:0] mode_now;
    logic              tight_flow;
    logic              rx_hold;
    int unsigned       src_gap;
    int unsigned       rx_stall;
    int                words_added;
    int                words_sent;
    int                words_checked;
    int                fail_count;
    int                mode_writes;
    int                n_overflow;
    int                n_underflow;

    // Reverse all four bytes of a word.
    function automatic logic [WORD_W-1:0] flip_bytes(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Expected result of one word under the given mode.
    function automatic ieee_result_t predict_result(input logic [MODE_W-1:0] m,
                                                    input logic [WORD_W-1:0] w,
                                                    input logic lst);
        ieee_result_t r;
        logic [WORD_W-1:0] src;
        logic        neg;
        logic [6:0]  hex_exp;
        logic [23:0] mant;
        int          shift;
        int          bexp;
        r.status = ST_OK;
        r.last   = lst;
        src      = (m == MODE_REV_CONVERT) ? flip_bytes(w) : w;
        case (m)
            MODE_CONVERT, MODE_REV_CONVERT: begin
                neg     = src[31];
                hex_exp = src[30:24];
                mant    = src[23:0];
                if (mant == '0 || hex_exp == '0) begin
                    r.word = {neg, 31'd0};
                end else begin
                    // Shift the leading one up to bit 23 of the fraction.
                    shift = 0;
                    while (!mant[23]) begin
                        mant  = mant << 1;
                        shift = shift + 1;
                    end
                    // 0.F * 16^(E-64) equals 1.m * 2^(4*(E-64) - 1 - shift).
                    bexp = 4 * (int'(hex_exp) - 64) - 1 - shift + 127;
                    if (bexp >= 255) begin
                        r.status = ST_OVERFLOW;
                        r.word   = {neg, 8'hff, 23'd0};
                    end else if (bexp <= 0) begin
                        r.status = ST_UNDERFLOW;
                        r.word   = {neg, 31'd0};
                    end else begin
                        r.word = {neg, bexp[7:0], mant[22:0]};
                    end
                end
            end
            MODE_SWAP_HALVES: r.word = {w[23:16], w[31:24], w[7:0], w[15:8]};
            MODE_REV_ONLY:    r.word = flip_bytes(w);
            default:          r.word = w;
        endcase
        return r;
    endfunction

    // Random IBM single, biased toward the range edges and the zero forms.
    function automatic logic [WORD_W-1:0] pick_hex_float();
        int unsigned pick;
        logic [6:0]  hex_exp;
        logic [23:0] mant;
        logic        neg;
        pick = $urandom_range(0, 9);
        neg  = 1'($urandom_range(0, 1));
        mant = 24'($urandom()) | 24'h80_0000;
        mant = mant >> $urandom_range(0, 23);
        if (pick == 0) begin
            return $urandom();
        end else if (pick == 1) begin
            if ($urandom_range(0, 1) == 0) begin
                return {neg, 7'($urandom_range(1, 127)), 24'd0};
            end
            return {neg, 7'd0, 24'($urandom())};
        end else if (pick <= 5) begin
            hex_exp = 7'($urandom_range(1, 127));
        end else if (pick <= 7) begin
            hex_exp = 7'($urandom_range(28, 37));
        end else begin
            hex_exp = 7'($urandom_range(92, 100));
        end
        return {neg, hex_exp, mant};
    endfunction

    task automatic add_word(input logic [WORD_W-1:0] w, input logic lst);
        word_item_t it;
        it.word = w;
        it.last = lst;
        pending_words.push_back(it);
        words_added++;
    endtask

    // Wait until every queued word has come back as a checked result.
    task automatic wait_drained();
        while (words_checked != words_added) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // One write transaction on the configuration channel; called just after an edge.
    task automatic write_mode(input logic [MODE_W-1:0] m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.mode  <= m;
        @(posedge clk);
        while (!cfg_ch.ready) begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        mode_now     = m;
        mode_writes++;
    endtask

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender: offers queued words, with a random gap after each transaction.
    always @(posedge clk) begin : feed_words
        word_item_t  nxt;
        int unsigned gap_now;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap     <= 0;
        end else if (!(in_ch.valid && !in_ch.ready)) begin
            gap_now = src_gap;
            if (in_ch.valid) begin
                predicted_results.push_back(
                    predict_result(mode_now, in_ch.in_word, in_ch.last_in));
                words_sent <= words_sent + 1;
                gap_now = tight_flow ? 0 : $urandom_range(0, 9);
            end
            if (gap_now != 0) begin
                in_ch.valid <= 1'b0;
                src_gap     <= gap_now - 1;
            end else if (pending_words.size() != 0) begin
                nxt = pending_words.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.in_word <= nxt.word;
                in_ch.last_in <= nxt.last;
                src_gap       <= 0;
            end else begin
                in_ch.valid <= 1'b0;
                src_gap     <= 0;
            end
        end
    end

    // Receiver: checks each result transaction, then stalls for a random count.
    always @(posedge clk) begin : collect_results
        ieee_result_t want;
        int unsigned  stall_now;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall     <= 0;
        end else begin
            stall_now = rx_stall;
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result: out_word %h, status %0d", out_ch.out_word,
                           out_ch.status);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    words_checked++;
                    if (want.status == ST_OVERFLOW) n_overflow++;
                    if (want.status == ST_UNDERFLOW) n_underflow++;
                    if (out_ch.out_word !== want.word) begin
                        $error("out_word: expected %h, actual %h", want.word, out_ch.out_word);
                        fail_count++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                        fail_count++;
                    end
                    if (out_ch.last_out !== want.last) begin
                        $error("last_out: expected %0d, actual %0d", want.last,
                               out_ch.last_out);
                        fail_count++;
                    end
                end
                stall_now = tight_flow ? 0 : $urandom_range(0, 9);
            end
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
                rx_stall     <= stall_now;
            end else if (stall_now != 0) begin
                out_ch.ready <= 1'b0;
                rx_stall     <= stall_now - 1;
            end else begin
                out_ch.ready <= 1'b1;
                rx_stall     <= 0;
            end
        end
    end

    // Long receiver hold-off mid-run so that both register stages fill and the input stalls.
    initial begin : long_hold
        rx_hold = 1'b0;
        wait (words_sent >= HOLD_AFTER);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Overall time limit.
    initial begin : watchdog
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus: directed words first, then random phases across all mode settings.
    initial begin : stimulus
        logic [MODE_W-1:0] plan [RANDOM_PHASES];
        logic [MODE_W-1:0] m;
        in_ch.valid   = 1'b0;
        in_ch.in_word = '0;
        in_ch.last_in = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.mode   = MODE_CONVERT;
        mode_now      = MODE_CONVERT;
        tight_flow    = 1'b0;
        words_added   = 0;
        words_sent    = 0;
        words_checked = 0;
        fail_count    = 0;
        mode_writes   = 0;
        n_overflow    = 0;
        n_underflow   = 0;
        rst_n         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Convert mode out of reset: zero forms, range edges and plain values.
        add_word(32'h0000_0000, 1'b0);   // positive zero
        add_word(32'h8000_0000, 1'b1);   // negative zero
        add_word(32'h4100_0000, 1'b0);   // zero fraction, nonzero exponent
        add_word(32'h80ff_ffff, 1'b0);   // zero exponent keeps the sign
        add_word(32'h4110_0000, 1'b1);   // one
        add_word(32'hc110_0000, 1'b0);   // minus one
        add_word(32'h2140_0000, 1'b0);   // smallest normal exponent
        add_word(32'h2120_0000, 1'b0);   // one step below: underflow
        add_word(32'h8100_0001, 1'b1);   // deep underflow, negative
        add_word(32'h6020_0000, 1'b0);   // finite, biased exponent 252
        add_word(32'h6040_0000, 1'b0);   // one step above: still finite, biased exponent 253
        add_word(32'h7fff_ffff, 1'b1);   // largest input magnitude
        add_word(32'hffff_ffff, 1'b0);   // all ones, negative overflow
        add_word(32'h4000_0001, 1'b1);   // maximum leading zero count
        wait_drained();

        write_mode(MODE_REV_CONVERT);
        add_word(32'h0000_1041, 1'b0);
        add_word(32'h0000_10c1, 1'b1);
        wait_drained();
        write_mode(MODE_SWAP_HALVES);
        add_word(32'h1234_5678, 1'b0);
        add_word(32'hffff_0000, 1'b1);
        wait_drained();
        write_mode(MODE_REV_ONLY);
        add_word(32'h89ab_cdef, 1'b1);
        add_word(32'h0000_0001, 1'b0);
        wait_drained();
        write_mode(MODE_PASS);
        add_word(32'hdead_beef, 1'b0);
        add_word(32'h7fff_ffff, 1'b1);
        wait_drained();
        write_mode(MODE_SPARE_HI);
        add_word(32'ha5a5_a5a5, 1'b1);
        wait_drained();

        // Random phases; the convert modes get well-formed words with random content.
        plan = '{MODE_CONVERT, MODE_SWAP_HALVES, MODE_REV_CONVERT, MODE_REV_ONLY,
                 MODE_PASS, MODE_SPARE_LO, MODE_SPARE_MID, MODE_SPARE_HI,
                 MODE_CONVERT, MODE_REV_CONVERT};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            m = plan[p];
            write_mode(m);
            tight_flow <= ($urandom_range(0, 3) == 0);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (m == MODE_CONVERT) begin
                    add_word(pick_hex_float(), 1'($urandom_range(0, 1)));
                end else if (m == MODE_REV_CONVERT) begin
                    add_word(flip_bytes(pick_hex_float()), 1'($urandom_range(0, 1)));
                end else begin
                    add_word($urandom(), 1'($urandom_range(0, 1)));
                end
            end
            wait_drained();
        end
        tight_flow <= 1'b0;
        repeat (10) @(posedge clk);

        // Every queued word must have come back exactly once.
        if (predicted_results.size() != 0 || words_checked != words_added) begin
            $error("results: expected %0d, actual %0d", words_added, words_checked);
            fail_count++;
        end

        $display("Checked %0d results over %0d mode writes, every mode code included.",
                 words_checked, mode_writes);
        $display("Conversions saturated to infinity: %0d, flushed to zero: %0d.",
                 n_overflow, n_underflow);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ibm2ieee_pkg.sv
design/ibm2ieee_in_if.sv
design/ibm2ieee_out_if.sv
design/ibm2ieee_cfg_if.sv
design/ibm_to_ieee_float_convert.sv
verif/ibm_to_ieee_float_convert_tb.sv
